// ----- src/steering_safety_supervisor_macros.svh -----
`ifndef STEERING_SAFETY_SUPERVISOR_MACROS_SVH
`define STEERING_SAFETY_SUPERVISOR_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SSUP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("steering supervisor check failed");

// next-cycle implication, sampled on clock, off during reset
`define SSUP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("steering supervisor check failed");

`endif

// ----- src/ssup_pkg.sv -----
`timescale 1ns / 1ps

package ssup_pkg;

   localparam int AGE_BITS_DEFAULT = 16;
   localparam int TIMEOUT_BITS     = 16;
   localparam int QUEUE_DEPTH      = 4;
   localparam int ADDR_BITS        = 5;
   localparam int DATA_BITS        = 32;
   localparam int MASK_BITS        = 5;

   localparam logic [11:0]        ANGLE_CEIL = 12'd3142;
   localparam logic signed [11:0] TEMP_LIMIT = 12'sd800;

   localparam logic [1:0] CMD_SETPOINT = 2'd0;
   localparam logic [1:0] CMD_FEEDBACK = 2'd1;
   localparam logic [1:0] CMD_LIMIT    = 2'd2;
   localparam logic [1:0] CMD_TICK     = 2'd3;

   localparam logic [2:0] CAUSE_PASSED   = 3'd0;
   localparam logic [2:0] CAUSE_BLOCKED  = 3'd1;
   localparam logic [2:0] CAUSE_CMD_TO   = 3'd2;
   localparam logic [2:0] CAUSE_SERVO    = 3'd3;
   localparam logic [2:0] CAUSE_OVERCUR  = 3'd4;
   localparam logic [2:0] CAUSE_OVERTEMP = 3'd5;

   localparam logic [2:0] REG_MAX_ANGLE   = 3'd0;
   localparam logic [2:0] REG_SERVO       = 3'd1;
   localparam logic [2:0] REG_CUR_LIMIT   = 3'd2;
   localparam logic [2:0] REG_CMD_TO      = 3'd3;
   localparam logic [2:0] REG_FB_TO       = 3'd4;
   localparam logic [2:0] REG_LEFT_SENSOR = 3'd5;
   localparam logic [2:0] REG_RIGHT_SENSOR= 3'd6;

   localparam logic [11:0] RST_MAX_ANGLE    = 12'd524;
   localparam logic [7:0]  RST_SERVO        = 8'd1;
   localparam logic [15:0] RST_CUR_LIMIT    = 16'd2000;
   localparam logic [15:0] RST_CMD_TO       = 16'd25;
   localparam logic [15:0] RST_FB_TO        = 16'd25;
   localparam logic [7:0]  RST_LEFT_SENSOR  = 8'd0;
   localparam logic [7:0]  RST_RIGHT_SENSOR = 8'd1;

   // job mask bits: setpoint command, then tick causes in emit order
   localparam int JOB_SETPOINT = 0;
   localparam int JOB_CMD_TO   = 1;
   localparam int JOB_SERVO    = 2;
   localparam int JOB_OVERCUR  = 3;
   localparam int JOB_OVERTEMP = 4;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] angle_mrad;
      logic [7:0]         feedback_servo;
      logic [15:0]        fault_bits;
      logic               torque_on;
      logic [15:0]        current_ma;
      logic signed [11:0] temp_decideg;
      logic [7:0]         sensor_number;
      logic               sensor_active;
   } req_type;

   typedef struct packed {
      logic signed [12:0] goal_mrad;
      logic [7:0]         target_servo;
      logic [15:0]        goal_current_ma;
      logic [2:0]         cause;
      logic               estop_latched;
      logic               healthy_now;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [11:0] max_angle_mrad;
      logic [7:0]  servo_number;
      logic [15:0] current_limit_ma;
      logic [15:0] command_timeout_periods;
      logic [15:0] feedback_timeout_periods;
      logic [7:0]  left_sensor_number;
      logic [7:0]  right_sensor_number;
   } cfg_type;

   typedef struct packed {
      logic signed [12:0]   goal_mrad;
      logic                 pass;
      logic [MASK_BITS-1:0] mask;
      logic                 estop;
      logic                 healthy;
   } job_type;

endpackage

// ----- src/steering_safety_supervisor.sv -----
`timescale 1ns / 1ps

// channel     | ports                                        | beat taken when
// ------------+----------------------------------------------+--------------------------------
// request     | push, full, req_data                         | push && !full
// response    | empty, pop, rsp_data                         | pop && !empty
// registers   | psel, penable, pwrite, paddr, pwdata, prdata | psel && penable && pwrite
//
// a request beat is classified and applied to the state in the cycle it is taken; one
// request beat per cycle while the job queue has room
// a setpoint gives one response, a tick zero to four, one per cycle out of the back end
// while the output is free or popped; a tick firing all checks holds it until all four leave
// a job passes the job queue and work register before its first response is registered
// synchronous reset restores registers and clears state, queue and output register
// a stalled response side fills the four-entry job queue, then full rises

module steering_safety_supervisor #(
   parameter int AGE_BITS = ssup_pkg::AGE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  ssup_pkg::req_type              req_data,
   output logic                           empty,
   input  logic                           pop,
   output ssup_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ssup_pkg::ADDR_BITS-1:0] paddr,
   input  logic [ssup_pkg::DATA_BITS-1:0] pwdata,
   output logic [ssup_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready
);

   ssup_pkg::cfg_type cfg;
   ssup_pkg::job_type job, q_data;
   logic              job_push, q_full, q_empty, q_pop, accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   ssup_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ssup_front #(
      .AGE_BITS (AGE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cfg      (cfg),
      .job_push (job_push),
      .job      (job)
   );

   ssup_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   ssup_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .rsp     (rsp_data)
   );

endmodule

// ----- src/ssup_csr.sv -----
`timescale 1ns / 1ps

module ssup_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ssup_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [ssup_pkg::DATA_BITS-1:0]     pwdata,
   output logic [ssup_pkg::DATA_BITS-1:0]     prdata,
   output logic                               pready,
   output ssup_pkg::cfg_type                  cfg
);

   ssup_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index  = paddr[ssup_pkg::ADDR_BITS-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            ssup_pkg::REG_MAX_ANGLE:    cfg_in.max_angle_mrad           = pwdata[11:0];
            ssup_pkg::REG_SERVO:        cfg_in.servo_number             = pwdata[7:0];
            ssup_pkg::REG_CUR_LIMIT:    cfg_in.current_limit_ma         = pwdata[15:0];
            ssup_pkg::REG_CMD_TO:       cfg_in.command_timeout_periods  = pwdata[15:0];
            ssup_pkg::REG_FB_TO:        cfg_in.feedback_timeout_periods = pwdata[15:0];
            ssup_pkg::REG_LEFT_SENSOR:  cfg_in.left_sensor_number       = pwdata[7:0];
            ssup_pkg::REG_RIGHT_SENSOR: cfg_in.right_sensor_number      = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ssup_pkg::REG_MAX_ANGLE:    prdata = 32'(cfg_ff.max_angle_mrad);
         ssup_pkg::REG_SERVO:        prdata = 32'(cfg_ff.servo_number);
         ssup_pkg::REG_CUR_LIMIT:    prdata = 32'(cfg_ff.current_limit_ma);
         ssup_pkg::REG_CMD_TO:       prdata = 32'(cfg_ff.command_timeout_periods);
         ssup_pkg::REG_FB_TO:        prdata = 32'(cfg_ff.feedback_timeout_periods);
         ssup_pkg::REG_LEFT_SENSOR:  prdata = 32'(cfg_ff.left_sensor_number);
         ssup_pkg::REG_RIGHT_SENSOR: prdata = 32'(cfg_ff.right_sensor_number);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_angle_mrad           <= ssup_pkg::RST_MAX_ANGLE;
         cfg_ff.servo_number             <= ssup_pkg::RST_SERVO;
         cfg_ff.current_limit_ma         <= ssup_pkg::RST_CUR_LIMIT;
         cfg_ff.command_timeout_periods  <= ssup_pkg::RST_CMD_TO;
         cfg_ff.feedback_timeout_periods <= ssup_pkg::RST_FB_TO;
         cfg_ff.left_sensor_number       <= ssup_pkg::RST_LEFT_SENSOR;
         cfg_ff.right_sensor_number      <= ssup_pkg::RST_RIGHT_SENSOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/ssup_front.sv -----
`timescale 1ns / 1ps

module ssup_front #(
   parameter int AGE_BITS = ssup_pkg::AGE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  ssup_pkg::req_type req,
   input  ssup_pkg::cfg_type cfg,
   output logic              job_push,
   output ssup_pkg::job_type job
);

   localparam int CW = (AGE_BITS > ssup_pkg::TIMEOUT_BITS) ? AGE_BITS : ssup_pkg::TIMEOUT_BITS;

   logic                left_ff, left_in;
   logic                right_ff, right_in;
   logic                ok_ff, ok_in;
   logic                estop_ff, estop_in;
   logic [15:0]         faults_ff, faults_in;
   logic [15:0]         current_ff, current_in;
   logic signed [11:0]  temp_ff, temp_in;
   logic [AGE_BITS-1:0] cmd_age_ff, cmd_age_in;
   logic [AGE_BITS-1:0] fb_age_ff, fb_age_in;

   logic [11:0]         lim;
   logic signed [16:0]  ang, lim_pos, lim_neg, clamped;
   logic [AGE_BITS-1:0] cmd_age_inc, fb_age_inc;
   logic                safe;

   assign lim     = (cfg.max_angle_mrad > ssup_pkg::ANGLE_CEIL) ? ssup_pkg::ANGLE_CEIL
                                                                : cfg.max_angle_mrad;
   assign ang     = {req.angle_mrad[15], req.angle_mrad};
   assign lim_pos = {5'b0, lim};
   assign lim_neg = -lim_pos;

   always_comb begin
      priority if (ang > lim_pos) begin
         clamped = lim_pos;
      end else if (ang < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = ang;
      end
   end

   assign safe = !((clamped < 0) && left_ff) && !((clamped > 0) && right_ff);

   assign cmd_age_inc = (cmd_age_ff == '1) ? cmd_age_ff : AGE_BITS'(cmd_age_ff + 1'b1);
   assign fb_age_inc  = (fb_age_ff == '1) ? fb_age_ff : AGE_BITS'(fb_age_ff + 1'b1);

   always_comb begin
      left_in    = left_ff;
      right_in   = right_ff;
      ok_in      = ok_ff;
      estop_in   = estop_ff;
      faults_in  = faults_ff;
      current_in = current_ff;
      temp_in    = temp_ff;
      cmd_age_in = cmd_age_ff;
      fb_age_in  = fb_age_ff;
      job        = '0;
      job.goal_mrad = clamped[12:0];
      if (accept) begin
         unique case (req.cmd)
            ssup_pkg::CMD_SETPOINT: begin
               cmd_age_in = '0;
               job.pass   = safe && ok_ff && !estop_ff;
               job.mask[ssup_pkg::JOB_SETPOINT] = 1'b1;
            end
            ssup_pkg::CMD_FEEDBACK: begin
               if (req.feedback_servo == cfg.servo_number) begin
                  fb_age_in  = '0;
                  faults_in  = req.fault_bits;
                  current_in = req.current_ma;
                  temp_in    = req.temp_decideg;
                  ok_in      = (req.fault_bits == '0) && req.torque_on;
               end
            end
            ssup_pkg::CMD_LIMIT: begin
               priority if (req.sensor_number == cfg.left_sensor_number) begin
                  left_in = req.sensor_active;
               end else if (req.sensor_number == cfg.right_sensor_number) begin
                  right_in = req.sensor_active;
               end else begin
                  right_in = right_ff;
               end
            end
            ssup_pkg::CMD_TICK: begin
               cmd_age_in = cmd_age_inc;
               fb_age_in  = fb_age_inc;
               job.mask[ssup_pkg::JOB_CMD_TO] =
                  CW'(cmd_age_inc) > CW'(cfg.command_timeout_periods);
               if (CW'(fb_age_inc) > CW'(cfg.feedback_timeout_periods)) begin
                  ok_in = 1'b0;
               end
               if (faults_ff != '0) begin
                  ok_in    = 1'b0;
                  estop_in = 1'b1;
                  job.mask[ssup_pkg::JOB_SERVO] = 1'b1;
               end
               if (current_ff > cfg.current_limit_ma) begin
                  estop_in = 1'b1;
                  job.mask[ssup_pkg::JOB_OVERCUR] = 1'b1;
               end
               if (temp_ff > ssup_pkg::TEMP_LIMIT) begin
                  estop_in = 1'b1;
                  job.mask[ssup_pkg::JOB_OVERTEMP] = 1'b1;
               end
            end
         endcase
      end
      job.estop   = estop_in;
      job.healthy = ok_in;
   end

   assign job_push = accept && (job.mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= 1'b0;
         right_ff   <= 1'b0;
         ok_ff      <= 1'b0;
         estop_ff   <= 1'b0;
         faults_ff  <= '0;
         current_ff <= '0;
         temp_ff    <= '0;
         cmd_age_ff <= '0;
         fb_age_ff  <= '0;
      end else begin
         left_ff    <= left_in;
         right_ff   <= right_in;
         ok_ff      <= ok_in;
         estop_ff   <= estop_in;
         faults_ff  <= faults_in;
         current_ff <= current_in;
         temp_ff    <= temp_in;
         cmd_age_ff <= cmd_age_in;
         fb_age_ff  <= fb_age_in;
      end
   end

endmodule

// ----- src/ssup_queue.sv -----
`timescale 1ns / 1ps

module ssup_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  ssup_pkg::job_type wr_data,
   input  logic              rd_en,
   output ssup_pkg::job_type rd_data,
   output logic              full,
   output logic              empty
);

   localparam int PW = $clog2(ssup_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(ssup_pkg::QUEUE_DEPTH + 1);

   ssup_pkg::job_type slot_ff [ssup_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = (count_ff == CW'(ssup_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(ssup_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(ssup_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_wr && !do_rd) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_rd && !do_wr) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/ssup_back.sv -----
`timescale 1ns / 1ps

module ssup_back (
   input  logic              clock,
   input  logic              reset,
   input  ssup_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  ssup_pkg::job_type q_data,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output ssup_pkg::rsp_type rsp
);

   logic                           work_vld_ff, work_vld_in;
   ssup_pkg::job_type              work_ff;
   logic [ssup_pkg::MASK_BITS-1:0] mask_ff, mask_in;
   logic                           out_vld_ff, out_vld_in;
   ssup_pkg::rsp_type              rsp_ff;

   logic [ssup_pkg::MASK_BITS-1:0] pick, rest;
   logic                           can_emit, emit_last, load;
   logic [2:0]                     cause;

   assign pick      = mask_ff & (~mask_ff + 1'b1);
   assign rest      = mask_ff & ~pick;
   assign emit_last = (rest == '0);
   assign can_emit  = work_vld_ff && (!out_vld_ff || pop);
   assign load      = !work_vld_ff || (can_emit && emit_last);
   assign q_pop     = load && !q_empty;

   always_comb begin
      priority if (pick[ssup_pkg::JOB_SETPOINT]) begin
         cause = work_ff.pass ? ssup_pkg::CAUSE_PASSED : ssup_pkg::CAUSE_BLOCKED;
      end else if (pick[ssup_pkg::JOB_CMD_TO]) begin
         cause = ssup_pkg::CAUSE_CMD_TO;
      end else if (pick[ssup_pkg::JOB_SERVO]) begin
         cause = ssup_pkg::CAUSE_SERVO;
      end else if (pick[ssup_pkg::JOB_OVERCUR]) begin
         cause = ssup_pkg::CAUSE_OVERCUR;
      end else begin
         cause = ssup_pkg::CAUSE_OVERTEMP;
      end
   end

   always_comb begin
      mask_in     = mask_ff;
      work_vld_in = work_vld_ff;
      if (can_emit) begin
         mask_in = rest;
         if (emit_last) begin
            work_vld_in = 1'b0;
         end
      end
      if (q_pop) begin
         mask_in     = q_data.mask;
         work_vld_in = 1'b1;
      end
      out_vld_in = can_emit ? 1'b1 : (pop ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         work_ff <= q_data;
      end
      if (can_emit) begin
         rsp_ff.goal_mrad       <= (work_ff.pass && pick[ssup_pkg::JOB_SETPOINT])
                                   ? work_ff.goal_mrad : '0;
         rsp_ff.target_servo    <= cfg.servo_number;
         rsp_ff.goal_current_ma <= cfg.current_limit_ma;
         rsp_ff.cause           <= cause;
         rsp_ff.estop_latched   <= work_ff.estop;
         rsp_ff.healthy_now     <= work_ff.healthy;
         rsp_ff.last            <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_vld_ff <= 1'b0;
         mask_ff     <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         work_vld_ff <= work_vld_in;
         mask_ff     <= mask_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   assign empty = !out_vld_ff;
   assign rsp   = rsp_ff;

endmodule

// ----- src/ssup_checker.sv -----
`timescale 1ns / 1ps
`include "steering_safety_supervisor_macros.svh"

module ssup_checker (
   input logic              clock,
   input logic              reset,
   input logic              empty,
   input logic              pop,
   input ssup_pkg::rsp_type rsp_data
);

   // only a passed setpoint moves the servo off centre
   `SSUP_ASSERT_NOW(a_centre_unless_passed, !empty && (rsp_data.cause != ssup_pkg::CAUSE_PASSED), rsp_data.goal_mrad == 13'sd0)

   // a passed setpoint needs health, no latched stop, and is the only beat of its item
   `SSUP_ASSERT_NOW(a_passed_is_safe, !empty && (rsp_data.cause == ssup_pkg::CAUSE_PASSED), rsp_data.healthy_now && !rsp_data.estop_latched && rsp_data.last)

   // a blocked setpoint is a single beat
   `SSUP_ASSERT_NOW(a_blocked_single, !empty && (rsp_data.cause == ssup_pkg::CAUSE_BLOCKED), rsp_data.last)

   // a waiting beat holds until popped
   `SSUP_ASSERT_NEXT(a_hold_beat, !empty && !pop, !empty && $stable(rsp_data))

endmodule

bind steering_safety_supervisor ssup_checker u_checker (.*);

// ----- bench/steering_safety_supervisor_test.sv -----
`timescale 1ns / 1ps

module steering_safety_supervisor_test;

   class command_scoreboard;
      ssup_pkg::cfg_type  cfg;
      logic signed [12:0] target_mrad;
      bit                 left_hit, right_hit, servo_ok, estop;
      logic [15:0]        faults, current;
      logic signed [11:0] temperature;
      longint unsigned    command_age, feedback_age;
      ssup_pkg::rsp_type  expected_commands[$];
      int                 mismatches;

      function new();
         cfg = ssup_pkg::cfg_type'{ssup_pkg::RST_MAX_ANGLE, ssup_pkg::RST_SERVO,
                                   ssup_pkg::RST_CUR_LIMIT, ssup_pkg::RST_CMD_TO,
                                   ssup_pkg::RST_FB_TO, ssup_pkg::RST_LEFT_SENSOR,
                                   ssup_pkg::RST_RIGHT_SENSOR};
         target_mrad = '0;
         left_hit = 0;
         right_hit = 0;
         servo_ok = 0;
         estop = 0;
         faults = '0;
         current = '0;
         temperature = '0;
         command_age = 0;
         feedback_age = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [31:0] value);
         case (index)
            ssup_pkg::REG_MAX_ANGLE:    cfg.max_angle_mrad = value[11:0];
            ssup_pkg::REG_SERVO:        cfg.servo_number = value[7:0];
            ssup_pkg::REG_CUR_LIMIT:    cfg.current_limit_ma = value[15:0];
            ssup_pkg::REG_CMD_TO:       cfg.command_timeout_periods = value[15:0];
            ssup_pkg::REG_FB_TO:        cfg.feedback_timeout_periods = value[15:0];
            ssup_pkg::REG_LEFT_SENSOR:  cfg.left_sensor_number = value[7:0];
            ssup_pkg::REG_RIGHT_SENSOR: cfg.right_sensor_number = value[7:0];
            default: ;
         endcase
      endfunction

      function longint unsigned aged(longint unsigned count);
         longint unsigned top;
         top = (64'd1 << ssup_pkg::AGE_BITS_DEFAULT) - 1;
         return (count < top) ? count + 1 : top;
      endfunction

      // applies one beat to the mirrored state and queues the commands it sends
      function void note_request(ssup_pkg::req_type beat);
         logic signed [12:0] goals[4];
         logic [2:0]         causes[4];
         int                 count;
         int                 ceiling;
         int                 angle;
         bit                 clear;
         ssup_pkg::rsp_type  command;
         count = 0;
         case (beat.cmd)
            ssup_pkg::CMD_SETPOINT: begin
               ceiling = (cfg.max_angle_mrad > ssup_pkg::ANGLE_CEIL)
                         ? int'(ssup_pkg::ANGLE_CEIL) : int'(cfg.max_angle_mrad);
               angle = beat.angle_mrad;
               if (angle > ceiling) angle = ceiling;
               if (angle < -ceiling) angle = -ceiling;
               target_mrad = 13'(angle);
               command_age = 0;
               clear = !((angle < 0 && left_hit) || (angle > 0 && right_hit));
               if (clear && servo_ok && !estop) begin
                  goals[count] = 13'(angle);
                  causes[count] = ssup_pkg::CAUSE_PASSED;
               end else begin
                  goals[count] = '0;
                  causes[count] = ssup_pkg::CAUSE_BLOCKED;
               end
               count++;
            end
            ssup_pkg::CMD_FEEDBACK: begin
               if (beat.feedback_servo == cfg.servo_number) begin
                  feedback_age = 0;
                  faults = beat.fault_bits;
                  current = beat.current_ma;
                  temperature = beat.temp_decideg;
                  servo_ok = (beat.fault_bits == 0) && beat.torque_on;
               end
            end
            ssup_pkg::CMD_LIMIT: begin
               if (beat.sensor_number == cfg.left_sensor_number)
                  left_hit = beat.sensor_active;
               else if (beat.sensor_number == cfg.right_sensor_number)
                  right_hit = beat.sensor_active;
            end
            ssup_pkg::CMD_TICK: begin
               command_age = aged(command_age);
               feedback_age = aged(feedback_age);
               if (command_age > cfg.command_timeout_periods) begin
                  target_mrad = '0;
                  goals[count] = '0;
                  causes[count] = ssup_pkg::CAUSE_CMD_TO;
                  count++;
               end
               if (feedback_age > cfg.feedback_timeout_periods) servo_ok = 0;
               if (faults != 0) begin
                  servo_ok = 0;
                  estop = 1;
                  goals[count] = '0;
                  causes[count] = ssup_pkg::CAUSE_SERVO;
                  count++;
               end
               if (current > cfg.current_limit_ma) begin
                  estop = 1;
                  goals[count] = '0;
                  causes[count] = ssup_pkg::CAUSE_OVERCUR;
                  count++;
               end
               if (temperature > ssup_pkg::TEMP_LIMIT) begin
                  estop = 1;
                  goals[count] = '0;
                  causes[count] = ssup_pkg::CAUSE_OVERTEMP;
                  count++;
               end
            end
            default: ;
         endcase
         for (int k = 0; k < count; k++) begin
            command.goal_mrad = goals[k];
            command.target_servo = cfg.servo_number;
            command.goal_current_ma = cfg.current_limit_ma;
            command.cause = causes[k];
            command.estop_latched = estop;
            command.healthy_now = servo_ok;
            command.last = (k == count - 1);
            expected_commands.push_back(command);
         end
      endfunction

      function void flag(string field, logic signed [16:0] want, logic signed [16:0] got);
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      endfunction

      function void check_command(ssup_pkg::rsp_type got);
         ssup_pkg::rsp_type want;
         if (expected_commands.size() == 0) begin
            $display("%0t: command beat with nothing expected, got %p", $time, got);
            mismatches++;
            return;
         end
         want = expected_commands.pop_front();
         if (got.goal_mrad !== want.goal_mrad) flag("goal_mrad", want.goal_mrad, got.goal_mrad);
         if (got.target_servo !== want.target_servo)
            flag("target_servo", want.target_servo, got.target_servo);
         if (got.goal_current_ma !== want.goal_current_ma)
            flag("goal_current_ma", want.goal_current_ma, got.goal_current_ma);
         if (got.cause !== want.cause) flag("cause", want.cause, got.cause);
         if (got.estop_latched !== want.estop_latched)
            flag("estop_latched", want.estop_latched, got.estop_latched);
         if (got.healthy_now !== want.healthy_now)
            flag("healthy_now", want.healthy_now, got.healthy_now);
         if (got.last !== want.last) flag("last", want.last, got.last);
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           push = 1'b0;
   logic                           full;
   ssup_pkg::req_type              req_data = '0;
   logic                           empty;
   logic                           pop = 1'b0;
   ssup_pkg::rsp_type              rsp_data;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [ssup_pkg::ADDR_BITS-1:0] paddr = '0;
   logic [ssup_pkg::DATA_BITS-1:0] pwdata = '0;
   logic [ssup_pkg::DATA_BITS-1:0] prdata;
   logic                           pready;
   bit                             steady = 1'b0;

   command_scoreboard sb = new();

   steering_safety_supervisor DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) sb.check_command(rsp_data);
         if (push && !full) sb.note_request(req_data);
      end
   end

   function automatic int idle_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 45) return 0;
      if (roll < 85) return int'($urandom_range(1, 3));
      if (roll < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic ssup_pkg::req_type random_fields();
      ssup_pkg::req_type beat;
      beat.cmd = 2'($urandom);
      beat.angle_mrad = 16'($urandom);
      beat.feedback_servo = 8'($urandom);
      beat.fault_bits = 16'($urandom);
      beat.torque_on = 1'($urandom);
      beat.current_ma = 16'($urandom);
      beat.temp_decideg = 12'($urandom);
      beat.sensor_number = 8'($urandom);
      beat.sensor_active = 1'($urandom);
      return beat;
   endfunction

   function automatic ssup_pkg::req_type setpoint_beat(int angle);
      ssup_pkg::req_type beat;
      beat = random_fields();
      beat.cmd = ssup_pkg::CMD_SETPOINT;
      beat.angle_mrad = 16'(angle);
      return beat;
   endfunction

   function automatic ssup_pkg::req_type feedback_beat(logic [7:0] servo, logic [15:0] faults,
                                                       logic torque, logic [15:0] current,
                                                       int temp);
      ssup_pkg::req_type beat;
      beat = random_fields();
      beat.cmd = ssup_pkg::CMD_FEEDBACK;
      beat.feedback_servo = servo;
      beat.fault_bits = faults;
      beat.torque_on = torque;
      beat.current_ma = current;
      beat.temp_decideg = 12'(temp);
      return beat;
   endfunction

   function automatic ssup_pkg::req_type limit_beat(logic [7:0] sensor, logic active);
      ssup_pkg::req_type beat;
      beat = random_fields();
      beat.cmd = ssup_pkg::CMD_LIMIT;
      beat.sensor_number = sensor;
      beat.sensor_active = active;
      return beat;
   endfunction

   function automatic ssup_pkg::req_type tick_beat();
      ssup_pkg::req_type beat;
      beat = random_fields();
      beat.cmd = ssup_pkg::CMD_TICK;
      return beat;
   endfunction

   // safe feedback keeps the stop unlatched so setpoints keep getting through
   function automatic ssup_pkg::req_type shaped_item(bit safe);
      ssup_pkg::req_type beat;
      int                roll;
      beat = random_fields();
      roll = int'($urandom_range(0, 99));
      if (roll < 35) begin
         beat.cmd = ssup_pkg::CMD_SETPOINT;
         if ($urandom_range(0, 1)) beat.angle_mrad = 16'(int'($urandom_range(0, 6600)) - 3300);
      end else if (roll < 60) begin
         beat.cmd = ssup_pkg::CMD_FEEDBACK;
         if ($urandom_range(0, 9) != 0) beat.feedback_servo = sb.cfg.servo_number;
         if ($urandom_range(0, 5) != 0) beat.torque_on = 1'b1;
         if (safe) begin
            beat.fault_bits = '0;
            beat.current_ma = 16'($urandom_range(0, sb.cfg.current_limit_ma));
            if ($urandom_range(0, 3) != 0)
               beat.temp_decideg = 12'(int'($urandom_range(0, 1200)) - 400);
            else
               beat.temp_decideg = 12'(int'($urandom_range(0, 2848)) - 2048);
         end else if ($urandom_range(0, 2) != 0) begin
            beat.fault_bits = '0;
         end
      end else if (roll < 75) begin
         beat.cmd = ssup_pkg::CMD_LIMIT;
         roll = int'($urandom_range(0, 9));
         if (roll < 5) beat.sensor_number = sb.cfg.left_sensor_number;
         else if (roll < 9) beat.sensor_number = sb.cfg.right_sensor_number;
      end else begin
         beat.cmd = ssup_pkg::CMD_TICK;
      end
      return beat;
   endfunction

   task automatic send_request(ssup_pkg::req_type beat);
      int gap;
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (full);
   endtask

   task automatic wait_quiet();
      push <= 1'b0;
      for (int n = 0; n < 20000; n++) begin
         @(posedge clock);
         if (sb.expected_commands.size() == 0) break;
      end
      // a beat with no command may still be in the pipe
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] value, int width);
      logic [31:0] mask;
      logic [31:0] data;
      mask = (width >= 32) ? '1 : ((32'd1 << width) - 1);
      data = ($urandom & ~mask) | (value & mask);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(index, data);
   endtask

   task automatic apply_settings(ssup_pkg::cfg_type s);
      write_register(ssup_pkg::REG_MAX_ANGLE, 32'(s.max_angle_mrad), 12);
      write_register(ssup_pkg::REG_SERVO, 32'(s.servo_number), 8);
      write_register(ssup_pkg::REG_CUR_LIMIT, 32'(s.current_limit_ma), 16);
      write_register(ssup_pkg::REG_CMD_TO, 32'(s.command_timeout_periods), 16);
      write_register(ssup_pkg::REG_FB_TO, 32'(s.feedback_timeout_periods), 16);
      write_register(ssup_pkg::REG_LEFT_SENSOR, 32'(s.left_sensor_number), 8);
      write_register(ssup_pkg::REG_RIGHT_SENSOR, 32'(s.right_sensor_number), 8);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic run_phase(ssup_pkg::cfg_type s, bit calm, int items);
      apply_settings(s);
      steady = calm;
      send_request(feedback_beat(sb.cfg.servo_number, '0, 1'b1, '0,
                                 int'($urandom_range(0, 1200)) - 400));
      repeat (items) send_request(shaped_item(1'b1));
      wait_quiet();
   endtask

   initial begin
      forever begin
         int gap;
         gap = (steady || reset) ? 0 : idle_gap();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: servo 1, clamp 524, left sensor 0, right sensor 1
      send_request(setpoint_beat(1000));
      send_request(feedback_beat(8'd1, 16'h0000, 1'b1, 16'd2000, 800));
      send_request(setpoint_beat(32767));
      send_request(setpoint_beat(-32768));
      send_request(setpoint_beat(0));
      send_request(limit_beat(8'd0, 1'b1));
      send_request(setpoint_beat(-100));
      send_request(setpoint_beat(100));
      send_request(limit_beat(8'd1, 1'b1));
      send_request(setpoint_beat(100));
      send_request(setpoint_beat(0));
      send_request(limit_beat(8'd0, 1'b0));
      send_request(limit_beat(8'd1, 1'b0));
      send_request(limit_beat(8'd77, 1'b1));
      send_request(feedback_beat(8'd2, 16'hffff, 1'b1, 16'hffff, 2047));
      send_request(tick_beat());
      send_request(feedback_beat(8'd1, 16'h0000, 1'b0, 16'd5, -400));
      send_request(setpoint_beat(5));
      send_request(feedback_beat(8'd1, 16'h0000, 1'b1, 16'd0, -2048));
      send_request(setpoint_beat(523));
      send_request(tick_beat());
      wait_quiet();

      run_phase(ssup_pkg::cfg_type'{12'd4095, 8'd255, 16'd65535, 16'd3, 16'd65535, 8'd7, 8'd9},
                0, 55);
      run_phase(ssup_pkg::cfg_type'{12'd0, 8'd0, 16'd0, 16'd1, 16'd1, 8'd5, 8'd5}, 1, 55);
      run_phase(ssup_pkg::cfg_type'{12'd3142, 8'd42, 16'd1500, 16'd65535, 16'd4, 8'd255, 8'd0},
                0, 55);
      run_phase(ssup_pkg::cfg_type'{12'd100, 8'd1, 16'd2000, 16'd2, 16'd25, 8'd0, 8'd1}, 0, 55);

      // faults latch the stop for good, so they come last
      apply_settings(ssup_pkg::cfg_type'{12'd2000, 8'd200, 16'd300, 16'd1, 16'd10, 8'd3, 8'd4});
      steady = 1'b0;
      send_request(feedback_beat(8'd200, 16'h0000, 1'b1, 16'd300, 800));
      send_request(setpoint_beat(500));
      send_request(tick_beat());
      send_request(feedback_beat(8'd200, 16'h8000, 1'b1, 16'hffff, 2047));
      send_request(tick_beat());
      send_request(setpoint_beat(-500));
      repeat (35) send_request(shaped_item(1'b0));
      wait_quiet();

      if (sb.expected_commands.size() != 0)
         $display("%0t: %0d expected command beats never arrived", $time,
                  sb.expected_commands.size());
      if (sb.mismatches == 0 && sb.expected_commands.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
